@@ rtl/core/polygon_edge_grid_zone_binning_assert.svh @@
`ifndef POLYGON_EDGE_GRID_ZONE_BINNING_ASSERT_SVH
`define POLYGON_EDGE_GRID_ZONE_BINNING_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PEGZB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define PEGZB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/pegzb_pkg.sv @@
package pegzb_pkg;

  localparam int MaxGridColumns = 16;
  localparam int MaxGridRows    = 16;
  localparam int MaxZoneSize    = 1024;
  localparam int DivSteps       = 12;
  localparam int QueueDepth     = 2;

  localparam logic [1:0] REG_ZONE_SIZE    = 2'd0;
  localparam logic [1:0] REG_GRID_COLUMNS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd2;

  typedef enum logic [1:0] {
    EDGE_ROW,
    EDGE_COL,
    EDGE_CROSS
  } edge_kind_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sz;
    logic signed [15:0] ex;
    logic signed [15:0] ez;
    logic [15:0]        region;
    logic signed [12:0] scx;
    logic signed [12:0] scz;
    logic signed [12:0] ecx;
    logic signed [12:0] ecz;
    edge_kind_t         kind;
  } edge_cmd_t;

  // clamped register values
  typedef struct packed {
    logic [10:0] size;
    logic [4:0]  cols;
    logic [4:0]  rows;
  } grid_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOAD,
    B_M0,
    B_M1,
    B_M2,
    B_M3,
    B_PASS1,
    B_WALK,
    B_TR,
    B_MUL,
    B_SUM,
    B_DIV,
    B_EMIT_HI,
    B_EMIT_LO,
    B_FLUSH
  } back_state_t;

endpackage

@@ rtl/core/pegzb_front.sv @@
module pegzb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  pegzb_pkg::grid_cfg_t  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    start_x,
  input  logic signed [15:0]    start_z,
  input  logic signed [15:0]    end_x,
  input  logic signed [15:0]    end_z,
  input  logic [15:0]           region_id,
  input  pegzb_pkg::queue_status_t q_status,
  output logic                  q_push,
  output pegzb_pkg::edge_cmd_t  q_data
);

  pegzb_pkg::front_state_t state, state_next;
  logic [3:0]  cnt;
  logic [15:0] region;

  // lanes: 0 start_x, 1 start_z, 2 end_x, 3 end_z
  logic signed [15:0] lane_in  [4];
  logic signed [15:0] crd      [4];
  logic [16:0]        lane_mag [4];
  logic [11:0]        num      [4];
  logic [10:0]        rem      [4];
  logic [11:0]        quo      [4];
  logic               neg      [4];
  logic [11:0]        step_sh  [4];
  logic               step_ge  [4];
  logic [10:0]        step_rem [4];
  logic [12:0]        quo_x    [4];
  logic signed [12:0] zone     [4];

  assign lane_in[0] = start_x;
  assign lane_in[1] = start_z;
  assign lane_in[2] = end_x;
  assign lane_in[3] = end_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_mag[i] = lane_in[i][15] ? 17'd0 - {1'b1, lane_in[i]} : {1'b0, lane_in[i]};
      step_sh[i]  = {rem[i], num[i][11]};
      step_ge[i]  = step_sh[i] >= {1'b0, cfg.size};
      step_rem[i] = step_ge[i] ? 11'(step_sh[i] - {1'b0, cfg.size}) : step_sh[i][10:0];
      quo_x[i]    = {1'b0, quo[i]};
      zone[i]     = neg[i] ? $signed(13'd0 - quo_x[i]) : $signed(quo_x[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pegzb_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      pegzb_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = pegzb_pkg::F_DIV;
      end
      pegzb_pkg::F_DIV: begin
        if (cnt == 4'd0) state_next = pegzb_pkg::F_PUSH;
      end
      pegzb_pkg::F_PUSH: begin
        q_push = !q_status.full;
        if (!q_status.full) state_next = pegzb_pkg::F_IDLE;
      end
      default: state_next = pegzb_pkg::F_IDLE;
    endcase
  end

  // |v|>>4 divided by zone size, one quotient bit per cycle per lane
  always_ff @(posedge clk) begin
    if (state == pegzb_pkg::F_IDLE && in_valid) begin
      region <= region_id;
      cnt    <= 4'(pegzb_pkg::DivSteps - 1);
      for (int i = 0; i < 4; i++) begin
        crd[i] <= lane_in[i];
        num[i] <= lane_mag[i][15:4];
        rem[i] <= '0;
        quo[i] <= '0;
        neg[i] <= lane_in[i][15];
      end
    end else if (state == pegzb_pkg::F_DIV) begin
      cnt <= cnt - 4'd1;
      for (int i = 0; i < 4; i++) begin
        num[i] <= {num[i][10:0], 1'b0};
        rem[i] <= step_rem[i];
        quo[i] <= {quo[i][10:0], step_ge[i]};
      end
    end
  end

  always_comb begin
    q_data.sx     = crd[0];
    q_data.sz     = crd[1];
    q_data.ex     = crd[2];
    q_data.ez     = crd[3];
    q_data.region = region;
    q_data.scx    = zone[0];
    q_data.scz    = zone[1];
    q_data.ecx    = zone[2];
    q_data.ecz    = zone[3];
    if (zone[1] == zone[3]) q_data.kind = pegzb_pkg::EDGE_ROW;
    else if (zone[0] == zone[2]) q_data.kind = pegzb_pkg::EDGE_COL;
    else q_data.kind = pegzb_pkg::EDGE_CROSS;
  end

endmodule

@@ rtl/core/pegzb_queue.sv @@
module pegzb_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  pegzb_pkg::edge_cmd_t     wr_data,
  input  logic                     pop,
  output pegzb_pkg::edge_cmd_t     rd_data,
  output pegzb_pkg::queue_status_t status
);

  localparam int PtrW = $clog2(pegzb_pkg::QueueDepth);

  pegzb_pkg::edge_cmd_t mem [pegzb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;

  assign rd_data      = mem[rd_ptr];
  assign status.full  = count == (PtrW + 1)'(pegzb_pkg::QueueDepth);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

@@ rtl/core/pegzb_back.sv @@
module pegzb_back (
  input  logic                     clk,
  input  logic                     rst,
  input  pegzb_pkg::grid_cfg_t     cfg,
  input  pegzb_pkg::queue_status_t q_status,
  input  pegzb_pkg::edge_cmd_t     q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               zone_col,
  output logic [3:0]               zone_row,
  output logic [15:0]              owner_region,
  output logic                     hit,
  output logic                     last
);

  pegzb_pkg::back_state_t state, state_next;
  pegzb_pkg::edge_cmd_t   cmd;

  logic               pass;       // 0: row boundaries, 1: column boundaries
  logic [4:0]         t, t_hi;
  logic signed [32:0] p_row, p_col;
  logic signed [31:0] d_row, d_col;
  logic signed [19:0] tr;
  logic signed [36:0] prod;
  logic [37:0]        rem;
  logic [41:0]        dsh;
  logic [3:0]         cnt;
  logic [11:0]        quo;
  logic               neg;
  logic               pend_v;
  logic [3:0]         pend_col, pend_row;

  logic [14:0]        raw;
  logic signed [16:0] dx, dz;
  logic signed [19:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [36:0] mul_p;
  logic [19:0]        traw;
  logic signed [15:0] tr_crd;
  logic signed [19:0] tr_next;
  logic signed [32:0] p_sel;
  logic signed [31:0] d_sel;
  logic signed [37:0] num_sum;
  logic [37:0]        num_abs;
  logic [31:0]        d_abs;
  logic               div_ge;
  logic [13:0]        quo_x;
  logic signed [13:0] qs;
  logic signed [13:0] cols_s, rows_s, t_s, t_m1;
  logic signed [13:0] rg_a, rg_b, rg_lim, rg_mn, rg_mx, rg_lo0, rg_lo, rg_hi;
  logic               rg_inc, rg_ok;
  logic signed [13:0] cand_col, cand_row;
  logic               emit_st, in_range, out_free, stall, adv, take;

  assign raw   = {cfg.size[10:0], 4'b0000};
  assign dx    = {cmd.sx[15], cmd.sx} - {cmd.ex[15], cmd.ex};
  assign dz    = {cmd.sz[15], cmd.sz} - {cmd.ez[15], cmd.ez};

  // shared multiplier for the M0-M3 and MUL steps, result always registered
  always_comb begin
    case (state)
      pegzb_pkg::B_M0: begin mul_a = 20'(cmd.ex); mul_b = dz; end
      pegzb_pkg::B_M1: begin mul_a = 20'(cmd.ez); mul_b = dx; end
      pegzb_pkg::B_M2: begin mul_a = $signed({5'b0, raw}); mul_b = dz; end
      pegzb_pkg::B_M3: begin mul_a = $signed({5'b0, raw}); mul_b = dx; end
      default: begin mul_a = tr; mul_b = pass ? dz : dx; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign traw    = {15'b0, t} * {5'b0, raw};
  assign tr_crd  = pass ? cmd.ex : cmd.ez;
  assign tr_next = $signed(traw) - 20'(tr_crd);

  assign p_sel   = pass ? p_col : p_row;
  assign d_sel   = pass ? d_col : d_row;
  assign num_sum = 38'(p_sel) + 38'(prod);
  assign num_abs = num_sum[37] ? 38'd0 - num_sum : num_sum;
  assign d_abs   = d_sel[31] ? 32'd0 - d_sel : d_sel;
  assign div_ge  = {4'b0, rem} >= dsh;
  assign quo_x   = {2'b0, quo};
  assign qs      = neg ? $signed(14'd0 - quo_x) : $signed(quo_x);

  assign cols_s = $signed({9'b0, cfg.cols});
  assign rows_s = $signed({9'b0, cfg.rows});
  assign t_s    = $signed({9'b0, t});
  assign t_m1   = t_s - 14'sd1;

  // clamped boundary or zone range for the next walk
  always_comb begin
    rg_a   = 14'(cmd.scx);
    rg_b   = 14'(cmd.ecx);
    rg_lim = cols_s;
    rg_inc = 1'b1;
    case (state)
      pegzb_pkg::B_LOAD: begin
        rg_inc = 1'b0;
        if (cmd.kind == pegzb_pkg::EDGE_COL) begin
          rg_a   = 14'(cmd.scz);
          rg_b   = 14'(cmd.ecz);
          rg_lim = rows_s - 14'sd1;
        end else begin
          rg_lim = cols_s - 14'sd1;
        end
      end
      pegzb_pkg::B_M3: begin
        rg_a   = 14'(cmd.scz);
        rg_b   = 14'(cmd.ecz);
        rg_lim = rows_s;
      end
      default: ;
    endcase
    rg_mn  = (rg_a < rg_b) ? rg_a : rg_b;
    rg_mx  = (rg_a < rg_b) ? rg_b : rg_a;
    rg_lo0 = rg_mn + (rg_inc ? 14'sd1 : 14'sd0);
    rg_lo  = (rg_lo0 < 14'sd0) ? 14'sd0 : rg_lo0;
    rg_hi  = (rg_mx < rg_lim) ? rg_mx : rg_lim;
    rg_ok  = rg_lo <= rg_hi;
  end

  always_comb begin
    cand_col = t_s;
    cand_row = t_s;
    case (state)
      pegzb_pkg::B_WALK: begin
        if (cmd.kind == pegzb_pkg::EDGE_COL) cand_col = 14'(cmd.scx);
        else cand_row = 14'(cmd.scz);
      end
      pegzb_pkg::B_EMIT_HI: begin
        if (pass) cand_row = qs;
        else cand_col = qs;
      end
      pegzb_pkg::B_EMIT_LO: begin
        if (pass) begin
          cand_col = t_m1;
          cand_row = qs;
        end else begin
          cand_col = qs;
          cand_row = t_m1;
        end
      end
      default: ;
    endcase
  end

  assign emit_st  = state == pegzb_pkg::B_WALK || state == pegzb_pkg::B_EMIT_HI ||
                    state == pegzb_pkg::B_EMIT_LO;
  assign in_range = cand_col >= 14'sd0 && cand_col < cols_s &&
                    cand_row >= 14'sd0 && cand_row < rows_s;
  assign out_free = !out_valid || out_ready;
  // a hit is held back one step so the final one can carry last
  assign stall    = emit_st && in_range && pend_v && !out_free;
  assign adv      = emit_st && !stall;
  assign take     = emit_st && in_range && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pegzb_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      pegzb_pkg::B_IDLE: begin
        q_pop = !q_status.empty;
        if (!q_status.empty) state_next = pegzb_pkg::B_LOAD;
      end
      pegzb_pkg::B_LOAD: begin
        if (cmd.kind == pegzb_pkg::EDGE_CROSS) state_next = pegzb_pkg::B_M0;
        else if (rg_ok) state_next = pegzb_pkg::B_WALK;
        else state_next = pegzb_pkg::B_FLUSH;
      end
      pegzb_pkg::B_M0: state_next = pegzb_pkg::B_M1;
      pegzb_pkg::B_M1: state_next = pegzb_pkg::B_M2;
      pegzb_pkg::B_M2: state_next = pegzb_pkg::B_M3;
      pegzb_pkg::B_M3: state_next = rg_ok ? pegzb_pkg::B_TR : pegzb_pkg::B_PASS1;
      pegzb_pkg::B_PASS1: state_next = rg_ok ? pegzb_pkg::B_TR : pegzb_pkg::B_FLUSH;
      pegzb_pkg::B_WALK: begin
        if (adv && t == t_hi) state_next = pegzb_pkg::B_FLUSH;
      end
      pegzb_pkg::B_TR:  state_next = pegzb_pkg::B_MUL;
      pegzb_pkg::B_MUL: state_next = pegzb_pkg::B_SUM;
      pegzb_pkg::B_SUM: state_next = pegzb_pkg::B_DIV;
      pegzb_pkg::B_DIV: begin
        if (cnt == 4'd0) state_next = pegzb_pkg::B_EMIT_HI;
      end
      pegzb_pkg::B_EMIT_HI: begin
        if (adv) state_next = pegzb_pkg::B_EMIT_LO;
      end
      pegzb_pkg::B_EMIT_LO: begin
        if (adv) begin
          if (t != t_hi) state_next = pegzb_pkg::B_TR;
          else if (pass) state_next = pegzb_pkg::B_FLUSH;
          else state_next = pegzb_pkg::B_PASS1;
        end
      end
      pegzb_pkg::B_FLUSH: begin
        if (out_free) state_next = pegzb_pkg::B_IDLE;
      end
      default: state_next = pegzb_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      pegzb_pkg::B_IDLE: begin
        if (!q_status.empty) cmd <= q_data;
      end
      pegzb_pkg::B_LOAD: begin
        pass <= 1'b0;
        t    <= rg_lo[4:0];
        t_hi <= rg_hi[4:0];
      end
      pegzb_pkg::B_M0: p_row <= mul_p[32:0];
      pegzb_pkg::B_M1: p_col <= mul_p[32:0];
      pegzb_pkg::B_M2: d_row <= mul_p[31:0];
      pegzb_pkg::B_M3: begin
        d_col <= mul_p[31:0];
        t     <= rg_lo[4:0];
        t_hi  <= rg_hi[4:0];
      end
      pegzb_pkg::B_PASS1: begin
        pass <= 1'b1;
        t    <= rg_lo[4:0];
        t_hi <= rg_hi[4:0];
      end
      pegzb_pkg::B_TR:  tr   <= tr_next;
      pegzb_pkg::B_MUL: prod <= mul_p;
      pegzb_pkg::B_SUM: begin
        rem <= num_abs;
        dsh <= {d_abs[30:0], 11'b0};
        neg <= num_sum[37] ^ d_sel[31];
        quo <= '0;
        cnt <= 4'(pegzb_pkg::DivSteps - 1);
      end
      pegzb_pkg::B_DIV: begin
        if (div_ge) rem <= rem - dsh[37:0];
        quo <= {quo[10:0], div_ge};
        dsh <= {1'b0, dsh[41:1]};
        cnt <= cnt - 4'd1;
      end
      pegzb_pkg::B_WALK, pegzb_pkg::B_EMIT_LO: begin
        if (adv && t != t_hi) t <= t + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        pend_v <= 1'b1;
        if (pend_v) out_valid <= 1'b1;
      end
      if (state == pegzb_pkg::B_FLUSH && out_free) begin
        out_valid <= 1'b1;
        pend_v    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_col <= cand_col[3:0];
      pend_row <= cand_row[3:0];
      if (pend_v) begin
        zone_col     <= pend_col;
        zone_row     <= pend_row;
        owner_region <= cmd.region;
        hit          <= 1'b1;
        last         <= 1'b0;
      end
    end
    if (state == pegzb_pkg::B_FLUSH && out_free) begin
      zone_col     <= pend_v ? pend_col : 4'd0;
      zone_row     <= pend_v ? pend_row : 4'd0;
      owner_region <= cmd.region;
      hit          <= pend_v;
      last         <= 1'b1;
    end
  end

endmodule

@@ rtl/core/polygon_edge_grid_zone_binning.sv @@
// Edge to grid zone binner. Each accepted edge beat (Q12.4 endpoints plus
// region id) yields the zones it touches as a run of result beats, the
// final one flagged with last; an edge touching nothing yields one beat with
// hit low. The front stage takes one edge at a time and runs the four
// endpoint zone divides, one quotient bit per cycle, then pushes the edge,
// waiting while the queue is full. A two-entry queue feeds the back stage,
// which emits one zone per cycle while the receiver is ready on edges that
// stay in one zone row or column, after a load step and with a flush step
// to finish. Other edges take four multiplier setup steps, then per crossed
// zone boundary three steps to form the numerator, a 12-step serial divide
// and two emit steps, at most 34 boundaries; a stalled receiver holds emits.
// Configuration is sampled as is and must only change while the block is idle.
`include "polygon_edge_grid_zone_binning_assert.svh"

module polygon_edge_grid_zone_binning (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_z,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_z,
  input  logic [15:0]        region_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         zone_col,
  output logic [3:0]         zone_row,
  output logic [15:0]        owner_region,
  output logic               hit,
  output logic               last
);

  logic [10:0] zone_size;
  logic [4:0]  grid_columns, grid_rows;
  pegzb_pkg::grid_cfg_t     cfg;
  pegzb_pkg::edge_cmd_t     q_wr, q_rd;
  pegzb_pkg::queue_status_t q_status;
  logic q_push, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_size    <= 11'd64;
      grid_columns <= 5'd16;
      grid_rows    <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pegzb_pkg::REG_ZONE_SIZE:    zone_size    <= cfg_data;
        pegzb_pkg::REG_GRID_COLUMNS: grid_columns <= cfg_data[4:0];
        pegzb_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (zone_size == 11'd0) cfg.size = 11'd1;
    else if (zone_size > 11'(pegzb_pkg::MaxZoneSize)) cfg.size = 11'(pegzb_pkg::MaxZoneSize);
    else cfg.size = zone_size;
    cfg.cols = (grid_columns > 5'(pegzb_pkg::MaxGridColumns)) ?
               5'(pegzb_pkg::MaxGridColumns) : grid_columns;
    cfg.rows = (grid_rows > 5'(pegzb_pkg::MaxGridRows)) ?
               5'(pegzb_pkg::MaxGridRows) : grid_rows;
  end

  pegzb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_z   (start_z),
    .end_x     (end_x),
    .end_z     (end_z),
    .region_id (region_id),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  pegzb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .status  (q_status)
  );

  pegzb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .zone_col     (zone_col),
    .zone_row     (zone_row),
    .owner_region (owner_region),
    .hit          (hit),
    .last         (last)
  );

  `PEGZB_ASSERT_NOW(a_nohit_is_last, out_valid && !hit, last)
  `PEGZB_ASSERT_NEXT(a_front_busy_after_accept, in_valid && in_ready, !in_ready)
  `PEGZB_ASSERT_NOW(a_no_push_when_full, q_status.full, !q_push)

endmodule
